// ===== hw/rtl/macro_op_fusion_pair_detector_core_defines.svh =====
// Assertion macros for the fusion pair detector core.
`ifndef MACRO_OP_FUSION_PAIR_DETECTOR_CORE_DEFINES_SVH
`define MACRO_OP_FUSION_PAIR_DETECTOR_CORE_DEFINES_SVH

// Condition holds at every edge outside reset.
`define MOFD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define MOFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MOFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mofd_pkg.sv =====
// Shared types and constants for the fusion pair detector.
`default_nettype none
package mofd_pkg;

  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;
  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] OPC_OP    = 7'h33;

  localparam logic [2:0] FN3_ADD  = 3'h0;
  localparam logic [2:0] FN3_SRL  = 3'h5;
  localparam logic [2:0] FN3_ANDI = 3'h7;
  localparam logic [6:0] FN7_ZERO = 7'h00;

  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

  localparam logic [2:0] KIND_SINGLE = 3'd0;
  localparam logic [2:0] KIND_LUI    = 3'd1;
  localparam logic [2:0] KIND_AUIPC  = 3'd2;
  localparam logic [2:0] KIND_ADD    = 3'd3;
  localparam logic [2:0] KIND_SHIFT  = 3'd4;

  // Result queue depth, power of two, at least 4.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [31:0] imm;
    logic        last;
  } item_t;

  // Up to two result items written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    item_t      item0;
    item_t      item1;
  } push_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mofd_match.sv =====
// Pair matcher: fusion kind and combined immediate for a pending/new word pair.
`default_nettype none
module mofd_match (
  input  wire logic [31:0] first_word,
  input  wire logic [31:0] second_word,
  output logic [2:0]       kind,
  output logic [31:0]      imm
);

  logic [6:0] a_opc, b_opc, a_fn7, b_fn7;
  logic [4:0] a_rd, b_rd, b_rs1;
  logic [2:0] a_fn3, b_fn3;
  logic       b_addi, a_add, b_add, a_srl, b_andi;
  logic       rs1_chain, rd_same;

  assign a_opc = first_word[6:0];
  assign b_opc = second_word[6:0];
  assign a_rd  = first_word[11:7];
  assign b_rd  = second_word[11:7];
  assign b_rs1 = second_word[19:15];
  assign a_fn3 = first_word[14:12];
  assign b_fn3 = second_word[14:12];
  assign a_fn7 = first_word[31:25];
  assign b_fn7 = second_word[31:25];

  assign rs1_chain = (b_rs1 == a_rd);
  assign rd_same   = (b_rd == a_rd);

  assign b_addi = (b_opc == mofd_pkg::OPC_OPIMM) && (b_fn3 == mofd_pkg::FN3_ADD);
  assign a_add  = (a_opc == mofd_pkg::OPC_OP) && (a_fn3 == mofd_pkg::FN3_ADD) &&
                  (a_fn7 == mofd_pkg::FN7_ZERO);
  assign b_add  = (b_opc == mofd_pkg::OPC_OP) && (b_fn3 == mofd_pkg::FN3_ADD) &&
                  (b_fn7 == mofd_pkg::FN7_ZERO);
  // SRL or SRLI; for SRLI the top seven bits are imm[11:5]
  assign a_srl  = ((a_opc == mofd_pkg::OPC_OP) || (a_opc == mofd_pkg::OPC_OPIMM)) &&
                  (a_fn3 == mofd_pkg::FN3_SRL) && (a_fn7 == mofd_pkg::FN7_ZERO);
  assign b_andi = (b_opc == mofd_pkg::OPC_OPIMM) && (b_fn3 == mofd_pkg::FN3_ANDI);

  always_comb begin
    if ((a_opc == mofd_pkg::OPC_LUI) && b_addi && rs1_chain && rd_same) begin
      kind = mofd_pkg::KIND_LUI;
    end else if ((a_opc == mofd_pkg::OPC_AUIPC) && b_addi && rs1_chain && rd_same) begin
      kind = mofd_pkg::KIND_AUIPC;
    end else if (a_add && b_add && rs1_chain) begin
      kind = mofd_pkg::KIND_ADD;
    end else if (a_srl && b_andi && rs1_chain) begin
      kind = mofd_pkg::KIND_SHIFT;
    end else begin
      kind = mofd_pkg::KIND_SINGLE;
    end
  end

  assign imm = (first_word & mofd_pkg::UPPER_MASK) +
               {{20{second_word[31]}}, second_word[31:20]};

endmodule
`default_nettype wire

// ===== hw/rtl/mofd_outq.sv =====
// Result queue: takes up to two items a cycle, hands out one while the output is not stalled.
`default_nettype none
module mofd_outq #(
  parameter int DEPTH = mofd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mofd_pkg::push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output mofd_pkg::item_t      out_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mofd_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_item  = mem_r[rd_ptr_r];
  // two free slots, not counting a pop in this cycle
  assign room      = (count_r <= CW'(DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + PW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign count_nxt  = count_r + CW'(push.cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= push.item1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/macro_op_fusion_pair_detector_core.sv =====
// An accepted word is held in the input register, then its result is written to the result queue before it is offered.
// Throughput: one instruction word per cycle while the queue has room; a word that flushes two
// singles pushes two items, absorbed by the result queue.
// The input register drains only when the queue has two free slots.
// Reset (synchronous, rst_n low) clears the pending flag and empties the queue.
`default_nettype none
`include "macro_op_fusion_pair_detector_core_defines.svh"
module macro_op_fusion_pair_detector_core #(
  parameter int QUEUE_DEPTH = mofd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_instruction,
  input  wire logic        in_end_of_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_fusion_kind,
  output logic [31:0]      out_first_word,
  output logic [31:0]      out_second_word,
  output logic [31:0]      out_combined_immediate,
  output logic             out_last_of_run
);

  logic            inr_v_r, inr_v_nxt;
  logic [31:0]     inr_word_r;
  logic            inr_eob_r;
  logic            pend_v_r, pend_v_nxt;
  logic [31:0]     pend_word_r, pend_word_nxt;
  logic            in_take, fire, room;
  logic [2:0]      match_kind;
  logic [31:0]     match_imm;
  mofd_pkg::push_t push;
  mofd_pkg::item_t out_item;

  assign fire     = inr_v_r && room;
  assign in_stall = inr_v_r && !fire;
  assign in_take  = in_valid && !in_stall;
  assign inr_v_nxt = in_take ? 1'b1 : (fire ? 1'b0 : inr_v_r);

  mofd_match u_match (
    .first_word  (pend_word_r),
    .second_word (inr_word_r),
    .kind        (match_kind),
    .imm         (match_imm)
  );

  always_comb begin
    push          = '0;
    pend_v_nxt    = pend_v_r;
    pend_word_nxt = pend_word_r;
    if (fire) begin
      if (!pend_v_r) begin
        if (inr_eob_r) begin
          push.cnt              = 2'd1;
          push.item0.kind       = mofd_pkg::KIND_SINGLE;
          push.item0.first_word = inr_word_r;
          push.item0.last       = 1'b1;
        end else begin
          pend_v_nxt    = 1'b1;
          pend_word_nxt = inr_word_r;
        end
      end else if (match_kind != mofd_pkg::KIND_SINGLE) begin
        push.cnt               = 2'd1;
        push.item0.kind        = match_kind;
        push.item0.first_word  = pend_word_r;
        push.item0.second_word = inr_word_r;
        push.item0.last        = 1'b1;
        if ((match_kind == mofd_pkg::KIND_LUI) || (match_kind == mofd_pkg::KIND_AUIPC)) begin
          push.item0.imm = match_imm;
        end
        pend_v_nxt = 1'b0;
      end else if (inr_eob_r) begin
        // flush: pending word, then the new word
        push.cnt              = 2'd2;
        push.item0.kind       = mofd_pkg::KIND_SINGLE;
        push.item0.first_word = pend_word_r;
        push.item1.kind       = mofd_pkg::KIND_SINGLE;
        push.item1.first_word = inr_word_r;
        push.item1.last       = 1'b1;
        pend_v_nxt            = 1'b0;
      end else begin
        push.cnt              = 2'd1;
        push.item0.kind       = mofd_pkg::KIND_SINGLE;
        push.item0.first_word = pend_word_r;
        push.item0.last       = 1'b1;
        pend_word_nxt         = inr_word_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      inr_v_r  <= inr_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inr_word_r <= in_instruction;
      inr_eob_r  <= in_end_of_block;
    end
    pend_word_r <= pend_word_nxt;
  end

  mofd_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_fusion_kind        = out_item.kind;
  assign out_first_word         = out_item.first_word;
  assign out_second_word        = out_item.second_word;
  assign out_combined_immediate = out_item.imm;
  assign out_last_of_run        = out_item.last;

  `MOFD_ASSERT_NEXT(a_fuse_clears_pending, fire && pend_v_r && (match_kind != mofd_pkg::KIND_SINGLE), !pend_v_r, "fused pair left a word pending")
  `MOFD_ASSERT_SAME(a_double_only_on_flush, push.cnt == 2'd2, pend_v_r && inr_eob_r && fire, "two items pushed without a flush")
  `MOFD_ASSERT_SAME(a_single_fields_zero, out_valid && (out_fusion_kind == mofd_pkg::KIND_SINGLE), (out_second_word == 32'd0) && (out_combined_immediate == 32'd0), "single item carries pair fields")

endmodule
`default_nettype wire

// ===== sim/macro_op_fusion_pair_detector_core_test.sv =====
// Self-checking testbench for the RV32 macro-op fusion pair detector core.
module macro_op_fusion_pair_detector_core_test;
  import mofd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_instruction;
  logic        in_end_of_block;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_fusion_kind;
  logic [31:0] out_first_word;
  logic [31:0] out_second_word;
  logic [31:0] out_combined_immediate;
  logic        out_last_of_run;

  macro_op_fusion_pair_detector_core u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_instruction         (in_instruction),
    .in_end_of_block        (in_end_of_block),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_fusion_kind        (out_fusion_kind),
    .out_first_word         (out_first_word),
    .out_second_word        (out_second_word),
    .out_combined_immediate (out_combined_immediate),
    .out_last_of_run        (out_last_of_run)
  );

  // Mirror of the detector's pending slot.
  logic        held_valid;
  logic [31:0] held_word;

  item_t fused_ops_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int words_sent;
  int ops_checked;
  int err_count;
  int kind_seen[5];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Instruction encoders.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(input logic [6:0] fn7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] fn3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {fn7, rs2, rs1, fn3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] fn3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, fn3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  // ---------------------------------------------------------------------------
  // Fusion predictor.
  // ---------------------------------------------------------------------------
  function automatic logic [2:0] fusion_kind_of(input logic [31:0] a, input logic [31:0] b);
    logic [6:0] a_opc, b_opc;
    logic [4:0] a_rd, b_rd, b_rs1;
    logic [2:0] a_fn3, b_fn3;
    logic [6:0] a_fn7, b_fn7;
    logic       b_addi, a_add, b_add, a_srl, b_andi;
    a_opc = a[6:0];   b_opc = b[6:0];
    a_rd  = a[11:7];  b_rd  = b[11:7];
    b_rs1 = b[19:15];
    a_fn3 = a[14:12]; b_fn3 = b[14:12];
    a_fn7 = a[31:25]; b_fn7 = b[31:25];
    b_addi = (b_opc == OPC_OPIMM) && (b_fn3 == FN3_ADD);
    a_add  = (a_opc == OPC_OP) && (a_fn3 == FN3_ADD) && (a_fn7 == FN7_ZERO);
    b_add  = (b_opc == OPC_OP) && (b_fn3 == FN3_ADD) && (b_fn7 == FN7_ZERO);
    // SRLI reuses the funct7 slot as imm[11:5]
    a_srl  = ((a_opc == OPC_OP) || (a_opc == OPC_OPIMM)) && (a_fn3 == FN3_SRL) &&
             (a_fn7 == FN7_ZERO);
    b_andi = (b_opc == OPC_OPIMM) && (b_fn3 == FN3_ANDI);
    if (a_opc == OPC_LUI && b_addi && b_rs1 == a_rd && b_rd == a_rd) return KIND_LUI;
    if (a_opc == OPC_AUIPC && b_addi && b_rs1 == a_rd && b_rd == a_rd) return KIND_AUIPC;
    if (a_add && b_add && b_rs1 == a_rd) return KIND_ADD;
    if (a_srl && b_andi && b_rs1 == a_rd) return KIND_SHIFT;
    return KIND_SINGLE;
  endfunction

  function automatic item_t make_op(input logic [2:0] kind, input logic [31:0] w1,
                                    input logic [31:0] w2, input logic [31:0] imm,
                                    input logic last);
    item_t op;
    op.kind        = kind;
    op.first_word  = w1;
    op.second_word = w2;
    op.imm         = imm;
    op.last        = last;
    return op;
  endfunction

  task automatic predict_fusion(input logic [31:0] w, input logic eob);
    logic [2:0]  kind;
    logic [31:0] imm;
    if (!held_valid) begin
      if (eob) fused_ops_q.push_back(make_op(KIND_SINGLE, w, '0, '0, 1'b1));
      else begin
        held_word  = w;
        held_valid = 1'b1;
      end
    end else begin
      kind = fusion_kind_of(held_word, w);
      if (kind != KIND_SINGLE) begin
        imm = '0;
        if (kind == KIND_LUI || kind == KIND_AUIPC)
          imm = (held_word & UPPER_MASK) + {{20{w[31]}}, w[31:20]};
        fused_ops_q.push_back(make_op(kind, held_word, w, imm, 1'b1));
        held_valid = 1'b0;
      end else if (eob) begin
        fused_ops_q.push_back(make_op(KIND_SINGLE, held_word, '0, '0, 1'b0));
        fused_ops_q.push_back(make_op(KIND_SINGLE, w, '0, '0, 1'b1));
        held_valid = 1'b0;
      end else begin
        fused_ops_q.push_back(make_op(KIND_SINGLE, held_word, '0, '0, 1'b1));
        held_word = w;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver side.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] w, input logic eob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_instruction  <= w;
    in_end_of_block <= eob;
    do @(posedge clk); while (in_stall);
    predict_fusion(w, eob);
    words_sent++;
  endtask

  // Hold the input off until every predicted item has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (fused_ops_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // ---------------------------------------------------------------------------
  // Result checker.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fused_ops_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got kind %0d first %h", $time,
                 out_fusion_kind, out_first_word);
        err_count++;
      end else begin
        want = fused_ops_q.pop_front();
        check_field("fusion_kind", 32'(want.kind), 32'(out_fusion_kind));
        check_field("first_word", want.first_word, out_first_word);
        check_field("second_word", want.second_word, out_second_word);
        check_field("combined_immediate", want.imm, out_combined_immediate);
        check_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
        if (out_fusion_kind < 5) kind_seen[out_fusion_kind]++;
        ops_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    // lone words with end mark, nothing pending
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    // lui+addi, positive and negative low part
    send_word(enc_u(20'h12345, 5'd5, OPC_LUI), 1'b0);
    send_word(enc_i(12'h678, 5'd5, FN3_ADD, 5'd5, OPC_OPIMM), 1'b0);
    send_word(enc_u(20'hFFFFF, 5'd1, OPC_LUI), 1'b0);
    send_word(enc_i(12'hFFF, 5'd1, FN3_ADD, 5'd1, OPC_OPIMM), 1'b0);
    // auipc+addi fused while carrying the end mark
    send_word(enc_u(20'h80000, 5'd31, OPC_AUIPC), 1'b0);
    send_word(enc_i(12'h800, 5'd31, FN3_ADD, 5'd31, OPC_OPIMM), 1'b1);
    // chained add, srl+andi, srli+andi
    send_word(enc_r(FN7_ZERO, 5'd2, 5'd1, FN3_ADD, 5'd3, OPC_OP), 1'b0);
    send_word(enc_r(FN7_ZERO, 5'd7, 5'd3, FN3_ADD, 5'd4, OPC_OP), 1'b0);
    send_word(enc_r(FN7_ZERO, 5'd2, 5'd6, FN3_SRL, 5'd6, OPC_OP), 1'b0);
    send_word(enc_i(12'h0FF, 5'd6, FN3_ANDI, 5'd6, OPC_OPIMM), 1'b0);
    send_word(enc_r(FN7_ZERO, 5'd3, 5'd8, FN3_SRL, 5'd7, OPC_OPIMM), 1'b0);
    send_word(enc_i(12'h007, 5'd7, FN3_ANDI, 5'd9, OPC_OPIMM), 1'b0);
    // near misses: op-imm that is not addi, rd mismatch, rs1 mismatch
    send_word(enc_u(20'hABCDE, 5'd5, OPC_LUI), 1'b0);
    send_word(enc_i(12'h001, 5'd5, 3'd2, 5'd5, OPC_OPIMM), 1'b0);
    send_word(enc_u(20'h00001, 5'd5, OPC_LUI), 1'b0);
    send_word(enc_i(12'h001, 5'd5, FN3_ADD, 5'd6, OPC_OPIMM), 1'b0);
    send_word(enc_u(20'h00002, 5'd10, OPC_AUIPC), 1'b0);
    send_word(enc_i(12'h001, 5'd11, FN3_ADD, 5'd10, OPC_OPIMM), 1'b0);
    // sll is not add, sra and srai are not srl
    send_word(enc_r(FN7_ZERO, 5'd2, 5'd1, 3'd1, 5'd3, OPC_OP), 1'b0);
    send_word(enc_r(FN7_ZERO, 5'd2, 5'd3, FN3_ADD, 5'd4, OPC_OP), 1'b0);
    send_word(enc_r(7'h20, 5'd2, 5'd6, FN3_SRL, 5'd6, OPC_OP), 1'b0);
    send_word(enc_i(12'h0FF, 5'd6, FN3_ANDI, 5'd6, OPC_OPIMM), 1'b0);
    send_word(enc_r(7'h20, 5'd4, 5'd6, FN3_SRL, 5'd6, OPC_OPIMM), 1'b0);
    // no match under the end mark: two singles flushed
    send_word(enc_i(12'h0FF, 5'd6, FN3_ANDI, 5'd6, OPC_OPIMM), 1'b1);
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
  endfunction

  task automatic test_random_stream(input int n_words);
    int          sent;
    int          sel;
    logic [4:0]  rd, rs1, rs2;
    logic [31:0] w1, w2, rnd;
    sent = 0;
    while (sent < n_words) begin
      rd  = pick_reg();
      rs1 = pick_reg();
      rs2 = pick_reg();
      rnd = $urandom;
      sel = $urandom_range(99);
      if (sel < 65) begin
        case ($urandom_range(3))
          0: begin
            w1 = enc_u(rnd[19:0], rd, OPC_LUI);
            w2 = enc_i(12'($urandom), rd, FN3_ADD, rd, OPC_OPIMM);
          end
          1: begin
            w1 = enc_u(rnd[19:0], rd, OPC_AUIPC);
            w2 = enc_i(12'($urandom), rd, FN3_ADD, rd, OPC_OPIMM);
          end
          2: begin
            w1 = enc_r(FN7_ZERO, rs2, rs1, FN3_ADD, rd, OPC_OP);
            w2 = enc_r(FN7_ZERO, pick_reg(), rd, FN3_ADD, pick_reg(), OPC_OP);
          end
          default: begin
            w1 = enc_r(FN7_ZERO, rs2, rs1, FN3_SRL, rd, rnd[0] ? OPC_OP : OPC_OPIMM);
            w2 = enc_i(12'($urandom), rd, FN3_ANDI, pick_reg(), OPC_OPIMM);
          end
        endcase
        // break a share of the pairs with one flipped bit
        if ($urandom_range(99) < 15) w2[$urandom_range(31)] ^= 1'b1;
        if ($urandom_range(99) < 10) w1[$urandom_range(31)] ^= 1'b1;
        send_word(w1, $urandom_range(99) < 5);
        send_word(w2, $urandom_range(99) < 12);
        sent += 2;
      end else begin
        w1 = (sel < 85) ? rnd : {rnd[31:7], rnd[1] ? OPC_OPIMM : OPC_OP};
        send_word(w1, $urandom_range(99) < 12);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_instruction  <= '0;
    in_end_of_block <= 1'b0;
    out_stall       <= 1'b0;
    held_valid      = 1'b0;
    held_word       = '0;
    words_sent      = 0;
    ops_checked     = 0;
    err_count       = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    send_idle_pct   = 15;
    recv_idle_pct   = 48;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    wait_drained();
    test_random_stream(340);
    wait_drained();
    send_idle_pct = 48;
    recv_idle_pct = 15;
    test_random_stream(340);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(340);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d words, checked %0d items under three idle/stall mixes.",
             words_sent, ops_checked);
    $display("Items by kind: single %0d, lui %0d, auipc %0d, add %0d, shift %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (err_count == 0 && fused_ops_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (fused_ops_q.size() != 0)
        $display("%0t: %0d predicted items never arrived", $time, fused_ops_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out at %0t", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mofd_pkg.sv
hw/rtl/mofd_match.sv
hw/rtl/mofd_outq.sv
hw/rtl/macro_op_fusion_pair_detector_core.sv
sim/macro_op_fusion_pair_detector_core_test.sv
